@@ hw/rtl/circle_pair_collision_resolve_macros.svh @@
// Assertion helpers for the circle pair collision block.
`ifndef CIRCLE_PAIR_COLLISION_RESOLVE_MACROS_SVH
`define CIRCLE_PAIR_COLLISION_RESOLVE_MACROS_SVH
`ifndef SYNTHESIS
`define CPCR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define CPCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define CPCR_ASSERT_IMP(label, clk, rst, ante, cons)
`define CPCR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/cpcr_pkg.sv @@
package cpcr_pkg;

   typedef struct packed {
      logic hit;
      logic coincident;
   } cpcr_class_type;

   typedef struct packed {
      logic empty;
      logic full;
   } cpcr_qstat_type;

endpackage

@@ hw/rtl/cpcr_front.sv @@
module cpcr_front #(
   parameter int W = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    take,
   input  logic signed [W-1:0]     a_pos_x,
   input  logic signed [W-1:0]     a_pos_y,
   input  logic signed [W-1:0]     a_vel_x,
   input  logic signed [W-1:0]     a_vel_y,
   input  logic [W-2:0]            a_radius,
   input  logic signed [W-1:0]     b_pos_x,
   input  logic signed [W-1:0]     b_pos_y,
   input  logic signed [W-1:0]     b_vel_x,
   input  logic signed [W-1:0]     b_vel_y,
   input  logic [W-2:0]            b_radius,
   output logic                    out_valid,
   output cpcr_pkg::cpcr_class_type out_class,
   output logic [13*W+1:0]         out_data
);
   import cpcr_pkg::*;

   localparam int PW = 11 * W + 2;

   logic signed [W:0] dx, dy;
   logic [W-1:0]      ux, uy, rs;

   logic              v1_ff, v2_ff, v3_ff;
   logic [PW-1:0]     p1_ff, p2_ff;
   logic [W-1:0]      ux_ff, uy_ff, rs_ff;
   logic [2*W-1:0]    sqx_ff, sqy_ff, rs2_ff;
   logic [2*W:0]      dsq;
   logic [13*W+1:0]   data_ff;
   cpcr_class_type    class_ff;

   assign dx = (W+1)'(b_pos_x) - (W+1)'(a_pos_x);
   assign dy = (W+1)'(b_pos_y) - (W+1)'(a_pos_y);
   assign ux = dx[W] ? W'(-dx) : W'(dx);
   assign uy = dy[W] ? W'(-dy) : W'(dy);
   assign rs = W'(a_radius) + W'(b_radius);
   assign dsq = (2*W+1)'(sqx_ff) + (2*W+1)'(sqy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= take;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff  <= {a_pos_x, a_pos_y, a_vel_x, a_vel_y, b_pos_x, b_pos_y, b_vel_x, b_vel_y,
                 ux, uy, dx[W], dy[W], rs};
      ux_ff  <= ux;
      uy_ff  <= uy;
      rs_ff  <= rs;
      p2_ff  <= p1_ff;
      sqx_ff <= (2*W)'(ux_ff) * (2*W)'(ux_ff);
      sqy_ff <= (2*W)'(uy_ff) * (2*W)'(uy_ff);
      rs2_ff <= (2*W)'(rs_ff) * (2*W)'(rs_ff);
      data_ff <= {p2_ff, dsq[2*W-1:0]};
      class_ff.hit <= dsq <= (2*W+1)'(rs2_ff);
      class_ff.coincident <= dsq == '0;
   end

   assign out_valid = v3_ff;
   assign out_class = class_ff;
   assign out_data  = data_ff;

endmodule

@@ hw/rtl/cpcr_queue.sv @@
module cpcr_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  cpcr_pkg::cpcr_class_type push_class,
   input  logic [WIDTH-1:0]         push_data,
   input  logic                     pop,
   output cpcr_pkg::cpcr_class_type head_class,
   output logic [WIDTH-1:0]         head_data,
   output cpcr_pkg::cpcr_qstat_type stat
);
   import cpcr_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [DEPTH];
   cpcr_class_type   class_ff [DEPTH];
   logic [AW-1:0]    wr_ff, rd_ff;
   logic [CW-1:0]    count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (pop) begin
            rd_ff <= (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + CW'(push) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff[wr_ff]  <= push_data;
         class_ff[wr_ff] <= push_class;
      end
   end

   assign head_data  = data_ff[rd_ff];
   assign head_class = class_ff[rd_ff];
   assign stat.empty = count_ff == '0;
   assign stat.full  = count_ff == CW'(DEPTH);

endmodule

@@ hw/rtl/cpcr_back.sv @@
module cpcr_back #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cpcr_pkg::cpcr_class_type q_class,
   input  logic [13*W+1:0]          q_data,
   input  cpcr_pkg::cpcr_qstat_type q_stat,
   output logic                     pop,
   output logic                     rsp_valid,
   output logic                     rsp_collided,
   output logic signed [W-1:0]      rsp_a_new_pos_x,
   output logic signed [W-1:0]      rsp_a_new_pos_y,
   output logic signed [W-1:0]      rsp_a_new_vel_x,
   output logic signed [W-1:0]      rsp_a_new_vel_y,
   output logic signed [W-1:0]      rsp_b_new_pos_x,
   output logic signed [W-1:0]      rsp_b_new_pos_y,
   output logic signed [W-1:0]      rsp_b_new_vel_x,
   output logic signed [W-1:0]      rsp_b_new_vel_y
);
   import cpcr_pkg::*;

   localparam int SW  = W + 5;
   localparam int VPW = W + F + 3;
   localparam int VSW = W + F + 4;
   localparam int CW  = $clog2(W + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SQRT = 3'd1;
   localparam logic [2:0] S_DIV  = 3'd2;
   localparam logic [2:0] S_MULP = 3'd3;
   localparam logic [2:0] S_MULV = 3'd4;
   localparam logic [2:0] S_VN   = 3'd5;
   localparam logic [2:0] S_MULI = 3'd6;
   localparam logic [2:0] S_FIN  = 3'd7;

   function automatic logic [W-1:0] sat_f(input logic signed [SW-1:0] v);
      logic [W-1:0] r;
      if (v[SW-1:W-1] == '0 || v[SW-1:W-1] == '1) begin
         r = v[W-1:0];
      end else if (v[SW-1]) begin
         r = {1'b1, {(W-1){1'b0}}};
      end else begin
         r = {1'b0, {(W-1){1'b1}}};
      end
      return r;
   endfunction

   // head entry fields
   logic signed [W-1:0] i_ax, i_ay, i_avx, i_avy, i_bx, i_by, i_bvx, i_bvy;
   logic [W-1:0]        i_ux, i_uy, i_rs;
   logic                i_sx, i_sy;
   logic [2*W-1:0]      i_dsq;

   assign {i_ax, i_ay, i_avx, i_avy, i_bx, i_by, i_bvx, i_bvy,
           i_ux, i_uy, i_sx, i_sy, i_rs, i_dsq} = q_data;

   logic [2:0]          st_ff, st_in;
   logic [CW-1:0]       cnt_ff;
   logic signed [W-1:0] ax_ff, ay_ff, avx_ff, avy_ff, bx_ff, by_ff, bvx_ff, bvy_ff;
   logic [W-1:0]        ux_ff, uy_ff, rs_ff;
   logic                sx_ff, sy_ff;
   logic [2*W-1:0]      x_ff;
   logic [W+1:0]        rem_ff;
   logic [W-1:0]        root_ff;
   logic [W:0]          rx_ff, ry_ff;
   logic [F:0]          qx_ff, qy_ff;
   logic [W+F:0]        pxp_ff, pyp_ff;
   logic signed [VPW-1:0] vpx_ff, vpy_ff;
   logic [W+1:0]        vnm_ff;
   logic                vgo_ff;
   logic [W+2:0]        ixm_ff, iym_ff;

   logic                valid_ff, coll_ff;
   logic [W-1:0]        o_ax_ff, o_ay_ff, o_avx_ff, o_avy_ff;
   logic [W-1:0]        o_bx_ff, o_by_ff, o_bvx_ff, o_bvy_ff;

   // square root step
   logic [W+1:0] rem2, trial;
   logic         sq_ge;
   assign rem2  = {rem_ff[W-1:0], x_ff[2*W-1:2*W-2]};
   assign trial = {root_ff, 2'b01};
   assign sq_ge = rem2 >= trial;

   // normal divide step
   logic         gx, gy;
   logic [W:0]   dfx, dfy;
   assign gx  = rx_ff >= (W+1)'(root_ff);
   assign gy  = ry_ff >= (W+1)'(root_ff);
   assign dfx = gx ? rx_ff - (W+1)'(root_ff) : rx_ff;
   assign dfy = gy ? ry_ff - (W+1)'(root_ff) : ry_ff;

   logic [W-1:0]          ov;
   logic signed [W:0]     dvx, dvy;
   logic signed [F+1:0]   nxs, nys;
   logic signed [VSW-1:0] vsum;
   logic [VSW-1:0]        vmag;
   logic [VPW-1:0]        ixp, iyp;
   logic signed [SW-1:0]  pxs, pys, ixs, iys;

   assign ov   = rs_ff - root_ff;
   assign dvx  = (W+1)'(avx_ff) - (W+1)'(bvx_ff);
   assign dvy  = (W+1)'(avy_ff) - (W+1)'(bvy_ff);
   assign nxs  = sx_ff ? -(F+2)'(qx_ff) : (F+2)'(qx_ff);
   assign nys  = sy_ff ? -(F+2)'(qy_ff) : (F+2)'(qy_ff);
   assign vsum = VSW'(vpx_ff) + VSW'(vpy_ff);
   assign vmag = vsum[VSW-1] ? VSW'(-vsum) : VSW'(vsum);
   assign ixp  = VPW'(vnm_ff) * VPW'(qx_ff);
   assign iyp  = VPW'(vnm_ff) * VPW'(qy_ff);
   assign pxs  = sx_ff ? -SW'(pxp_ff[W+F:F+1]) : SW'(pxp_ff[W+F:F+1]);
   assign pys  = sy_ff ? -SW'(pyp_ff[W+F:F+1]) : SW'(pyp_ff[W+F:F+1]);
   assign ixs  = sx_ff ? -SW'(ixm_ff) : SW'(ixm_ff);
   assign iys  = sy_ff ? -SW'(iym_ff) : SW'(iym_ff);

   assign pop = (st_ff == S_IDLE) && !q_stat.empty;

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (pop && q_class.hit && !q_class.coincident) st_in = S_SQRT;
         end
         S_SQRT: if (cnt_ff == CW'(W - 1)) st_in = S_DIV;
         S_DIV:  if (cnt_ff == CW'(F)) st_in = S_MULP;
         S_MULP: st_in = S_MULV;
         S_MULV: st_in = S_VN;
         S_VN:   st_in = S_MULI;
         S_MULI: st_in = S_FIN;
         S_FIN:  st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         valid_ff <= (pop && !(q_class.hit && !q_class.coincident)) || (st_ff == S_FIN);
      end
   end

   always_ff @(posedge clock) begin
      case (st_ff)
         S_IDLE: begin
            ax_ff  <= i_ax;  ay_ff  <= i_ay;  avx_ff <= i_avx; avy_ff <= i_avy;
            bx_ff  <= i_bx;  by_ff  <= i_by;  bvx_ff <= i_bvx; bvy_ff <= i_bvy;
            ux_ff  <= i_ux;  uy_ff  <= i_uy;  sx_ff  <= i_sx;  sy_ff  <= i_sy;
            rs_ff  <= i_rs;
            x_ff    <= i_dsq;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            coll_ff <= q_class.hit;
            o_ax_ff <= i_ax;  o_ay_ff <= i_ay;  o_avx_ff <= i_avx; o_avy_ff <= i_avy;
            o_bx_ff <= i_bx;  o_by_ff <= i_by;  o_bvx_ff <= i_bvx; o_bvy_ff <= i_bvy;
         end
         S_SQRT: begin
            rem_ff  <= sq_ge ? rem2 - trial : rem2;
            root_ff <= {root_ff[W-2:0], sq_ge};
            x_ff    <= {x_ff[2*W-3:0], 2'b00};
            cnt_ff  <= (cnt_ff == CW'(W - 1)) ? '0 : cnt_ff + 1'b1;
            rx_ff   <= (W+1)'(ux_ff);
            ry_ff   <= (W+1)'(uy_ff);
         end
         S_DIV: begin
            rx_ff  <= {dfx[W-1:0], 1'b0};
            ry_ff  <= {dfy[W-1:0], 1'b0};
            qx_ff  <= {qx_ff[F-1:0], gx};
            qy_ff  <= {qy_ff[F-1:0], gy};
            cnt_ff <= cnt_ff + 1'b1;
         end
         S_MULP: begin
            pxp_ff <= (W+F+1)'(qx_ff) * (W+F+1)'(ov);
            pyp_ff <= (W+F+1)'(qy_ff) * (W+F+1)'(ov);
         end
         S_MULV: begin
            vpx_ff <= VPW'(dvx) * VPW'(nxs);
            vpy_ff <= VPW'(dvy) * VPW'(nys);
         end
         S_VN: begin
            vnm_ff <= vmag[W+F+1:F];
            vgo_ff <= !vsum[VSW-1] && (vmag[W+F+1:F] != '0);
         end
         S_MULI: begin
            ixm_ff <= ixp[W+F+2:F];
            iym_ff <= iyp[W+F+2:F];
         end
         S_FIN: begin
            o_ax_ff <= sat_f(SW'(ax_ff) - pxs);
            o_ay_ff <= sat_f(SW'(ay_ff) - pys);
            o_bx_ff <= sat_f(SW'(bx_ff) + pxs);
            o_by_ff <= sat_f(SW'(by_ff) + pys);
            if (vgo_ff) begin
               o_avx_ff <= sat_f(SW'(avx_ff) - ixs);
               o_avy_ff <= sat_f(SW'(avy_ff) - iys);
               o_bvx_ff <= sat_f(SW'(bvx_ff) + ixs);
               o_bvy_ff <= sat_f(SW'(bvy_ff) + iys);
            end else begin
               o_avx_ff <= avx_ff;
               o_avy_ff <= avy_ff;
               o_bvx_ff <= bvx_ff;
               o_bvy_ff <= bvy_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid       = valid_ff;
   assign rsp_collided    = coll_ff;
   assign rsp_a_new_pos_x = o_ax_ff;
   assign rsp_a_new_pos_y = o_ay_ff;
   assign rsp_a_new_vel_x = o_avx_ff;
   assign rsp_a_new_vel_y = o_avy_ff;
   assign rsp_b_new_pos_x = o_bx_ff;
   assign rsp_b_new_pos_y = o_by_ff;
   assign rsp_b_new_vel_x = o_bvx_ff;
   assign rsp_b_new_vel_y = o_bvy_ff;

endmodule

@@ hw/rtl/circle_pair_collision_resolve.sv @@
// channel   | ports                     | transfer
// ----------+---------------------------+--------------------------------
// request   | start, busy, req_*        | edge with start high, busy low
// response  | rsp_valid, rsp_*          | every cycle rsp_valid is high
//
// Front classifies a pair in registered steps and takes one pair per cycle
// while busy is low. Back pops only when idle; a miss or coincident pair is
// answered from idle, a hit first runs a bit-serial root, then a divide.
// busy rises when QUEUE_DEPTH pairs sit in front stages and queue.
// Synchronous active-high reset empties pipeline and queue.
// Responses cannot be held off: each is shown for one cycle.
`include "circle_pair_collision_resolve_macros.svh"

module circle_pair_collision_resolve #(
   parameter int VALUE_BITS    = 32,
   parameter int FRACTION_BITS = 16,
   parameter int QUEUE_DEPTH   = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [VALUE_BITS-1:0] req_a_pos_x,
   input  logic signed [VALUE_BITS-1:0] req_a_pos_y,
   input  logic signed [VALUE_BITS-1:0] req_a_vel_x,
   input  logic signed [VALUE_BITS-1:0] req_a_vel_y,
   input  logic [VALUE_BITS-2:0]        req_a_radius,
   input  logic signed [VALUE_BITS-1:0] req_b_pos_x,
   input  logic signed [VALUE_BITS-1:0] req_b_pos_y,
   input  logic signed [VALUE_BITS-1:0] req_b_vel_x,
   input  logic signed [VALUE_BITS-1:0] req_b_vel_y,
   input  logic [VALUE_BITS-2:0]        req_b_radius,
   output logic                         rsp_valid,
   output logic                         rsp_collided,
   output logic signed [VALUE_BITS-1:0] rsp_a_new_pos_x,
   output logic signed [VALUE_BITS-1:0] rsp_a_new_pos_y,
   output logic signed [VALUE_BITS-1:0] rsp_a_new_vel_x,
   output logic signed [VALUE_BITS-1:0] rsp_a_new_vel_y,
   output logic signed [VALUE_BITS-1:0] rsp_b_new_pos_x,
   output logic signed [VALUE_BITS-1:0] rsp_b_new_pos_y,
   output logic signed [VALUE_BITS-1:0] rsp_b_new_vel_x,
   output logic signed [VALUE_BITS-1:0] rsp_b_new_vel_y
);
   import cpcr_pkg::*;

   localparam int DW    = 13 * VALUE_BITS + 2;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

   logic           take, pop, fe_valid;
   logic [OCC_W-1:0] occ_ff;
   cpcr_class_type fe_class, q_class;
   cpcr_qstat_type qstat;
   logic [DW-1:0]  fe_data, q_data;

   assign busy = occ_ff == OCC_W'(QUEUE_DEPTH);
   assign take = start && !busy;

   // pairs held between acceptance and pop
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_ff + OCC_W'(take) - OCC_W'(pop);
      end
   end

   cpcr_front #(.W(VALUE_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .a_pos_x   (req_a_pos_x),
      .a_pos_y   (req_a_pos_y),
      .a_vel_x   (req_a_vel_x),
      .a_vel_y   (req_a_vel_y),
      .a_radius  (req_a_radius),
      .b_pos_x   (req_b_pos_x),
      .b_pos_y   (req_b_pos_y),
      .b_vel_x   (req_b_vel_x),
      .b_vel_y   (req_b_vel_y),
      .b_radius  (req_b_radius),
      .out_valid (fe_valid),
      .out_class (fe_class),
      .out_data  (fe_data)
   );

   cpcr_queue #(.WIDTH(DW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fe_valid),
      .push_class (fe_class),
      .push_data  (fe_data),
      .pop        (pop),
      .head_class (q_class),
      .head_data  (q_data),
      .stat       (qstat)
   );

   cpcr_back #(.W(VALUE_BITS), .F(FRACTION_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_class         (q_class),
      .q_data          (q_data),
      .q_stat          (qstat),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_collided    (rsp_collided),
      .rsp_a_new_pos_x (rsp_a_new_pos_x),
      .rsp_a_new_pos_y (rsp_a_new_pos_y),
      .rsp_a_new_vel_x (rsp_a_new_vel_x),
      .rsp_a_new_vel_y (rsp_a_new_vel_y),
      .rsp_b_new_pos_x (rsp_b_new_pos_x),
      .rsp_b_new_pos_y (rsp_b_new_pos_y),
      .rsp_b_new_vel_x (rsp_b_new_vel_x),
      .rsp_b_new_vel_y (rsp_b_new_vel_y)
   );

   `CPCR_ASSERT_IMP(a_pop_nonempty, clock, reset, pop, !qstat.empty)
   `CPCR_ASSERT_IMP(a_push_room, clock, reset, fe_valid, !qstat.full)
   `CPCR_ASSERT_IMP(a_occ_bound, clock, reset, 1'b1, occ_ff <= OCC_W'(QUEUE_DEPTH))
   `CPCR_ASSERT_NEXT(a_take_count, clock, reset, take && !pop,
      occ_ff == OCC_W'($past(occ_ff) + 1'b1))

endmodule

@@ dv/tb_circle_pair_collision_resolve.sv @@
module tb_circle_pair_collision_resolve;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VB = 32;
   localparam int FB = 16;
   localparam longint SAT_MAX = 64'sd2147483647;
   localparam longint SAT_MIN = -64'sd2147483648;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      logic signed [VB-1:0] ax, ay, avx, avy;
      logic [VB-2:0]        ra;
      logic signed [VB-1:0] bx, by, bvx, bvy;
      logic [VB-2:0]        rb;
   } pair_type;

   typedef struct {
      logic                 hit;
      logic signed [VB-1:0] ax, ay, avx, avy, bx, by, bvx, bvy;
   } resolved_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [VB-1:0] req_a_pos_x = '0, req_a_pos_y = '0, req_a_vel_x = '0;
   logic signed [VB-1:0] req_a_vel_y = '0, req_b_pos_x = '0, req_b_pos_y = '0;
   logic signed [VB-1:0] req_b_vel_x = '0, req_b_vel_y = '0;
   logic [VB-2:0]        req_a_radius = '0, req_b_radius = '0;
   logic                 rsp_valid, rsp_collided;
   logic signed [VB-1:0] rsp_a_new_pos_x, rsp_a_new_pos_y, rsp_a_new_vel_x;
   logic signed [VB-1:0] rsp_a_new_vel_y, rsp_b_new_pos_x, rsp_b_new_pos_y;
   logic signed [VB-1:0] rsp_b_new_vel_x, rsp_b_new_vel_y;

   circle_pair_collision_resolve dut (.*);

   pair_type     pending_pairs[$];
   resolved_type expected_resolutions[$];
   int           errors = 0;
   int           sent = 0;
   int           total_items = 0;
   longint       cycles = 0;

   initial forever #5 clock = ~clock;

   function automatic logic signed [VB-1:0] clamp(longint v);
      if (v > SAT_MAX) v = SAT_MAX;
      if (v < SAT_MIN) v = SAT_MIN;
      return v[VB-1:0];
   endfunction

   function automatic longint trunc_shift(longint v, int s);
      longint m;
      m = (v < 0 ? -v : v) >>> s;
      return v < 0 ? -m : m;
   endfunction

   function automatic resolved_type resolve_pair(pair_type p);
      resolved_type r;
      longint ax, ay, bx, by, dx, dy, nx, ny, ov, px, py, vn, ix, iy;
      logic [65:0] dsq, rsq;
      logic [63:0] ux, uy, rs, rem, res, bitv, d;
      ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
      r.hit = 0;
      r.ax = p.ax; r.ay = p.ay; r.avx = p.avx; r.avy = p.avy;
      r.bx = p.bx; r.by = p.by; r.bvx = p.bvx; r.bvy = p.bvy;
      dx = bx - ax; dy = by - ay;
      ux = dx < 0 ? -dx : dx;
      uy = dy < 0 ? -dy : dy;
      dsq = 66'(ux) * 66'(ux) + 66'(uy) * 66'(uy);
      rs = 64'(p.ra) + 64'(p.rb);
      rsq = 66'(rs) * 66'(rs);
      if (dsq > rsq) return r;
      r.hit = 1;
      if (dsq == 0) return r;
      rem = dsq[63:0]; res = 0; bitv = 64'd1 << 62;
      while (bitv > dsq[63:0]) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      d = res;
      nx = (ux << FB) / d;
      ny = (uy << FB) / d;
      if (dx < 0) nx = -nx;
      if (dy < 0) ny = -ny;
      ov = rs - d;
      px = trunc_shift(nx * ov, FB + 1);
      py = trunc_shift(ny * ov, FB + 1);
      r.ax = clamp(ax - px); r.ay = clamp(ay - py);
      r.bx = clamp(bx + px); r.by = clamp(by + py);
      vn = trunc_shift((longint'(p.avx) - longint'(p.bvx)) * nx
                       + (longint'(p.avy) - longint'(p.bvy)) * ny, FB);
      if (vn > 0) begin
         ix = trunc_shift(vn * nx, FB);
         iy = trunc_shift(vn * ny, FB);
         r.avx = clamp(longint'(p.avx) - ix); r.avy = clamp(longint'(p.avy) - iy);
         r.bvx = clamp(longint'(p.bvx) + ix); r.bvy = clamp(longint'(p.bvy) + iy);
      end
      return r;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycles);
      errors++;
   endtask

   // driver
   always @(posedge clock) begin
      int idle_pct;
      pair_type p;
      if (reset) begin
         start <= 0;
      end else if (!start || !busy) begin
         idle_pct = sent < total_items / 3 ? 38 : (sent < 2 * total_items / 3 ? 57 : 0);
         if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct) begin
            p = pending_pairs.pop_front();
            req_a_pos_x <= p.ax; req_a_pos_y <= p.ay;
            req_a_vel_x <= p.avx; req_a_vel_y <= p.avy; req_a_radius <= p.ra;
            req_b_pos_x <= p.bx; req_b_pos_y <= p.by;
            req_b_vel_x <= p.bvx; req_b_vel_y <= p.bvy; req_b_radius <= p.rb;
            start <= 1;
            sent++;
         end else begin
            start <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pair_type p;
      resolved_type w;
      cycles++;
      if (!reset && start && !busy) begin
         p.ax = req_a_pos_x; p.ay = req_a_pos_y; p.avx = req_a_vel_x;
         p.avy = req_a_vel_y; p.ra = req_a_radius;
         p.bx = req_b_pos_x; p.by = req_b_pos_y; p.bvx = req_b_vel_x;
         p.bvy = req_b_vel_y; p.rb = req_b_radius;
         expected_resolutions.push_back(resolve_pair(p));
      end
      if (!reset && rsp_valid) begin
         if (expected_resolutions.size() == 0) begin
            report_mismatch("unexpected transfer", 0, 0);
         end else begin
            w = expected_resolutions.pop_front();
            if (rsp_collided !== w.hit) report_mismatch("collided", rsp_collided, w.hit);
            if (rsp_a_new_pos_x !== w.ax) report_mismatch("a_pos_x", rsp_a_new_pos_x, w.ax);
            if (rsp_a_new_pos_y !== w.ay) report_mismatch("a_pos_y", rsp_a_new_pos_y, w.ay);
            if (rsp_a_new_vel_x !== w.avx) report_mismatch("a_vel_x", rsp_a_new_vel_x, w.avx);
            if (rsp_a_new_vel_y !== w.avy) report_mismatch("a_vel_y", rsp_a_new_vel_y, w.avy);
            if (rsp_b_new_pos_x !== w.bx) report_mismatch("b_pos_x", rsp_b_new_pos_x, w.bx);
            if (rsp_b_new_pos_y !== w.by) report_mismatch("b_pos_y", rsp_b_new_pos_y, w.by);
            if (rsp_b_new_vel_x !== w.bvx) report_mismatch("b_vel_x", rsp_b_new_vel_x, w.bvx);
            if (rsp_b_new_vel_y !== w.bvy) report_mismatch("b_vel_y", rsp_b_new_vel_y, w.bvy);
         end
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic pair_type make_pair(longint ax, longint ay, longint avx, longint avy,
                                          longint ra, longint bx, longint by, longint bvx,
                                          longint bvy, longint rb);
      pair_type p;
      p.ax = ax[VB-1:0]; p.ay = ay[VB-1:0]; p.avx = avx[VB-1:0]; p.avy = avy[VB-1:0];
      p.ra = ra[VB-2:0];
      p.bx = bx[VB-1:0]; p.by = by[VB-1:0]; p.bvx = bvx[VB-1:0]; p.bvy = bvy[VB-1:0];
      p.rb = rb[VB-2:0];
      return p;
   endfunction

   function automatic longint rand32();
      return longint'(signed'($urandom()));
   endfunction

   function automatic pair_type random_pair();
      int     kind, s;
      longint span, ax, ay, ra, rb, vs;
      kind = $urandom_range(99);
      if (kind < 20)
         return make_pair(rand32(), rand32(), rand32(), rand32(), $urandom(),
                          rand32(), rand32(), rand32(), rand32(), $urandom());
      s = $urandom_range(4, 30);
      span = longint'(1) << s;
      ra = $urandom_range(0, span);
      rb = $urandom_range(0, span);
      vs = longint'(1) << $urandom_range(4, 31);
      if (kind < 35) begin
         ax = $urandom_range(0, 1) ? SAT_MAX - $urandom_range(0, span)
                                   : SAT_MIN + $urandom_range(0, span);
         ay = $urandom_range(0, 1) ? SAT_MAX - $urandom_range(0, span)
                                   : SAT_MIN + $urandom_range(0, span);
      end else begin
         ax = rand32(); ay = rand32();
      end
      return make_pair(ax, ay,
                       $urandom_range(0, 2 * vs) - vs, $urandom_range(0, 2 * vs) - vs, ra,
                       ax + $urandom_range(0, 4 * span) - 2 * span,
                       ay + $urandom_range(0, 4 * span) - 2 * span,
                       $urandom_range(0, 2 * vs) - vs, $urandom_range(0, 2 * vs) - vs, rb);
   endfunction

   initial begin
      longint one;
      one = 64'sd65536;
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(5, 7, one, 0, one, 5, 7, -one, 0, one));
      pending_pairs.push_back(make_pair(0, 0, one, 0, one, 2 * one, 0, -one, 0, one));
      pending_pairs.push_back(make_pair(0, 0, one, 0, one, one, 0, -one, 0, one));
      pending_pairs.push_back(make_pair(0, 0, -one, 0, one, one, 0, one, 0, one));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, one, one, 0, 0, 0, one));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, one, 3 * one, 0, 0, 0, one));
      pending_pairs.push_back(make_pair(0, 0, one, one, one, one, one, 0, 0, one));
      pending_pairs.push_back(make_pair(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX, 32'h7fffffff,
                                        SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 32'h7fffffff));
      pending_pairs.push_back(make_pair(SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, 32'h7fffffff,
                                        SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN, 32'h7fffffff));
      pending_pairs.push_back(make_pair(SAT_MAX, 0, SAT_MAX, 0, 32'h7fffffff,
                                        SAT_MAX - one, 0, SAT_MIN, 0, 32'h7fffffff));
      pending_pairs.push_back(make_pair(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN, 0,
                                        SAT_MIN, SAT_MIN, SAT_MAX, SAT_MAX, 0));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
      pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 1));
      pending_pairs.push_back(make_pair(0, 0, 2, 0, 1, 1, 1, 0, 0, 1));
      pending_pairs.push_back(make_pair(-one, -one, SAT_MAX, SAT_MIN, 4 * one,
                                        one, one, SAT_MIN, SAT_MAX, 4 * one));
      pending_pairs.push_back(make_pair(-1, -1, -1, -1, 32'h7fffffff,
                                        -1, -1, -1, -1, 32'h7fffffff));
      pending_pairs.push_back(make_pair(0, 0, one, 0, one, 0, one, 0, -one, one));
      repeat (1750) pending_pairs.push_back(random_pair());
      total_items = pending_pairs.size();
      repeat (10) @(posedge clock);
      reset <= 0;
      wait (pending_pairs.size() == 0 && !start);
      wait (expected_resolutions.size() == 0);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_resolutions.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
